FILE: rtl/mpq_pkg.sv
// ----------------------------------------------------------------------------
// mpq_pkg
// Shared types and constants for the max-priority queue block.
// ----------------------------------------------------------------------------
package mpq_pkg;

    // Default sizing, overridable from the top level
    localparam int DEPTH_DEF      = 64;
    localparam int PRIO_WIDTH_DEF = 16;

    // Fixed field widths on the streams and the config port
    localparam int MODE_W     = 2;
    localparam int PRIO_IN_W  = 16;
    localparam int MAX_OUT_W  = 16;
    localparam int COUNT_W    = 7;
    localparam int CAP_W      = 7;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    // Operation codes carried in the mode field
    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT = 2'd0,
        MODE_DELETE = 2'd1,
        MODE_QUERY  = 2'd2,
        MODE_RSVD   = 2'd3     // behaves as a status query
    } t_mode;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_EXEC = 2'd1,
        ST_SCAN = 2'd2,
        ST_OUT  = 2'd3
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic latch;        // capture the accepted item
        logic exec;         // run insert / error check, arm the scan
        logic scan_step;    // one read/compare/shift step of delete-max
        logic scan_finish;  // commit new maximum and count
        logic load_out;     // fill the output register
    } t_ctrl_cmd;

    // Datapath to controller
    typedef struct packed {
        logic del_go;       // latched item is a delete on a non-empty queue
        logic scan_done;    // every stored entry has been visited
        logic out_free;     // output register can take a result
    } t_ctrl_status;

endpackage

FILE: rtl/mpq_ctrl.sv
// ----------------------------------------------------------------------------
// mpq_ctrl
// Sequencer for the queue: accepts an item, runs the operation, then hands
// the status result to the output register.
// ----------------------------------------------------------------------------
module mpq_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  mpq_pkg::t_ctrl_status i_status,
    output mpq_pkg::t_ctrl_cmd    o_cmd
);
    import mpq_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_EXEC;
            end
            ST_EXEC: begin
                n_state = i_status.del_go ? ST_SCAN : ST_OUT;
            end
            ST_SCAN: begin
                if (i_status.scan_done) n_state = ST_OUT;
            end
            ST_OUT: begin
                if (i_status.out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.latch = i_in_valid;
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
            end
            ST_SCAN: begin
                o_cmd.scan_finish = i_status.scan_done;
                o_cmd.scan_step   = !i_status.scan_done;
            end
            ST_OUT: begin
                o_cmd.load_out = i_status.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

FILE: rtl/mpq_datapath.sv
// ----------------------------------------------------------------------------
// mpq_datapath
// Entry memory, count, tracked maximum, capacity register and output
// register. Delete-max is one pipelined pass over the stored entries: find
// the first entry equal to the maximum, shift later entries down one place
// and collect the maximum of what remains.
// ----------------------------------------------------------------------------
module mpq_datapath #(
    parameter int DEPTH      = mpq_pkg::DEPTH_DEF,
    parameter int PRIO_WIDTH = mpq_pkg::PRIO_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  mpq_pkg::t_ctrl_cmd                i_cmd,
    output mpq_pkg::t_ctrl_status             o_status,
    input  logic [mpq_pkg::S_TDATA_W-1:0]     i_s_tdata,
    input  logic                              i_cfg_valid,
    input  logic [mpq_pkg::CAP_W-1:0]         i_cfg_data,
    input  logic                              i_m_tready,
    output logic                              o_m_tvalid,
    output logic [mpq_pkg::M_TDATA_W-1:0]     o_m_tdata
);
    import mpq_pkg::*;

    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;

    // Entry memory, one write and one registered read per cycle
    logic [PRIO_WIDTH-1:0] mem [DEPTH];

    // Control and state registers
    logic [CAP_W-1:0]      r_cap;
    logic [CW-1:0]         r_count;
    logic [PRIO_WIDTH-1:0] r_max;
    logic [CW-1:0]         r_idx;
    logic                  r_pend;
    logic                  r_found;
    logic                  r_m_valid;

    // Payload registers
    t_mode                 r_mode;
    logic [PRIO_WIDTH-1:0] r_prio;
    logic                  r_err;
    logic [AW-1:0]         r_pidx;
    logic [PRIO_WIDTH-1:0] r_best;
    logic [PRIO_WIDTH-1:0] r_rd_data;
    logic [M_TDATA_W-1:0]  r_m_data;

    logic [31:0]           w_prio_ext;
    logic [CMPW-1:0]       w_cap_ext;
    logic [CMPW-1:0]       w_eff_cap;
    logic                  w_full;
    logic                  w_empty;
    logic                  w_ins_ok;
    logic                  w_rd_en;
    logic                  w_hit;
    logic                  w_we;
    logic [AW-1:0]         w_wa;
    logic [PRIO_WIDTH-1:0] w_wd;
    logic [31:0]           w_max_ext;
    logic [31:0]           w_count_ext;

    // Input field unpack: priority is masked to the stored width
    assign w_prio_ext = 32'(i_s_tdata[MODE_W +: PRIO_IN_W]);

    // Capacity saturates at the memory depth
    assign w_cap_ext = CMPW'(r_cap);
    assign w_eff_cap = (w_cap_ext > CMPW'(DEPTH)) ? CMPW'(DEPTH) : w_cap_ext;
    assign w_full    = CMPW'(r_count) >= w_eff_cap;
    assign w_empty   = (r_count == '0);
    assign w_ins_ok  = (r_mode == MODE_INSERT) && !w_full;

    // Scan pipeline: read index r_idx now, process index r_pidx data now
    assign w_rd_en = i_cmd.scan_step && (r_idx < r_count);
    assign w_hit   = !r_found && (r_rd_data == r_max);

    // Memory write: append on insert, shift down after the removed entry
    always_comb begin
        w_we = 1'b0;
        w_wa = r_count[AW-1:0];
        w_wd = r_prio;
        if (i_cmd.exec && w_ins_ok) begin
            w_we = 1'b1;
        end else if (i_cmd.scan_step && r_pend && r_found) begin
            w_we = 1'b1;
            w_wa = r_pidx - 1'b1;
            w_wd = r_rd_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) mem[w_wa] <= w_wd;
        if (w_rd_en) r_rd_data <= mem[r_idx[AW-1:0]];
    end

    // Status to the controller
    assign o_status.del_go    = (r_mode == MODE_DELETE) && !w_empty;
    assign o_status.scan_done = (r_idx == r_count) && !r_pend;
    assign o_status.out_free  = !r_m_valid || i_m_tready;

    // Queue state and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap     <= CAP_RESET;
            r_count   <= '0;
            r_max     <= '0;
            r_idx     <= '0;
            r_pend    <= 1'b0;
            r_found   <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) r_cap <= i_cfg_data;

            if (i_cmd.exec) begin
                r_idx   <= '0;
                r_pend  <= 1'b0;
                r_found <= 1'b0;
                if (w_ins_ok) begin
                    r_count <= r_count + 1'b1;
                    if (r_prio > r_max) r_max <= r_prio;
                end
            end

            if (i_cmd.scan_step) begin
                r_pend <= w_rd_en;
                if (w_rd_en) r_idx <= r_idx + 1'b1;
                if (r_pend && w_hit) r_found <= 1'b1;
            end

            if (i_cmd.scan_finish) begin
                r_max <= r_best;
                if (r_found) r_count <= r_count - 1'b1;
            end

            // Output register handshake
            if (i_cmd.load_out) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_mode <= t_mode'(i_s_tdata[MODE_W-1:0]);
            r_prio <= w_prio_ext[PRIO_WIDTH-1:0];
        end
        if (i_cmd.exec) begin
            r_best <= '0;
            r_err  <= ((r_mode == MODE_INSERT) && w_full) ||
                      ((r_mode == MODE_DELETE) && w_empty);
        end
        if (i_cmd.scan_step) begin
            if (w_rd_en) r_pidx <= r_idx[AW-1:0];
            if (r_pend && !w_hit && (r_rd_data > r_best)) r_best <= r_rd_data;
        end
        if (i_cmd.load_out) begin
            r_m_data <= {6'd0, r_err, w_full, w_empty,
                         w_count_ext[COUNT_W-1:0], w_max_ext[MAX_OUT_W-1:0]};
        end
    end

    assign w_max_ext   = 32'(r_max);
    assign w_count_ext = 32'(r_count);

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

endmodule

FILE: rtl/max_priority_queue_top.sv
// ----------------------------------------------------------------------------
// max_priority_queue_top
// Max-priority queue held as an unsorted array with a tracked maximum.
// ----------------------------------------------------------------------------
// Insert, status query and rejected ops run exec, then output load. Delete-max
// runs exec, one memory read per stored entry, one more for the last
// registered read, commit, output load. Output load waits while the output
// register holds an unaccepted result. Items are taken one at a time; the next
// item is accepted while a result waits in the output register.
// Reset is synchronous, active low: queue empty, maximum 0, capacity 64.
module max_priority_queue_top #(
    parameter int DEPTH      = mpq_pkg::DEPTH_DEF,
    parameter int PRIO_WIDTH = mpq_pkg::PRIO_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // tdata: [1:0] mode, [17:2] priority_req
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [mpq_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // tdata: [15:0] max_value, [22:16] count, [23] is_empty, [24] is_full,
    //        [25] op_error
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [mpq_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // capacity register write
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [mpq_pkg::CAP_W-1:0]     i_cfg_data
);
    import mpq_pkg::*;

    t_ctrl_cmd    w_cmd;
    t_ctrl_status w_status;

    // Capacity writes are always taken
    assign o_cfg_ready = 1'b1;

    mpq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    mpq_datapath #(
        .DEPTH      (DEPTH),
        .PRIO_WIDTH (PRIO_WIDTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_s_tdata   (s_axis_tdata),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_m_tready  (m_axis_tready),
        .o_m_tvalid  (m_axis_tvalid),
        .o_m_tdata   (m_axis_tdata)
    );

endmodule

FILE: rtl/mpq_checker.sv
// ----------------------------------------------------------------------------
// mpq_checker
// Port-level checks on the queue result stream, bound to the top level.
// ----------------------------------------------------------------------------
module mpq_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_m_tvalid,
    input logic                          i_m_tready,
    input logic [mpq_pkg::M_TDATA_W-1:0] i_m_tdata
);
    import mpq_pkg::*;

    // A stalled result holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata))
        else $error("result changed while stalled");

    // Empty flag agrees with the reported count
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid |-> (i_m_tdata[23] == (i_m_tdata[22:16] == 7'd0)))
        else $error("is_empty disagrees with count");

    // An empty queue reports a zero maximum
    a_empty_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && i_m_tdata[23] |-> (i_m_tdata[15:0] == 16'd0))
        else $error("nonzero maximum on empty queue");

    // No result is pending right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_m_tvalid)
        else $error("result valid after reset");

endmodule

bind max_priority_queue_top mpq_checker u_mpq_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata)
);

FILE: sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the max-priority queue. A short table of directed
// items and capacity writes runs first, then phases of random insert-heavy
// and delete-heavy runs, each at its own capacity. Every result on the output
// stream is compared field by field with a cycle-free model of the queue.
// ----------------------------------------------------------------------------
module tb_top;
    import mpq_pkg::*;

    localparam int  Q_DEPTH     = 64;
    localparam int  CYCLE_LIMIT = 1_000_000;
    localparam int  TAIL_CYCLES = 80;     // longest delete plus margin

    // Result fields, packed to match m_axis_tdata[25:0]
    typedef struct packed {
        logic                 op_error;
        logic                 is_full;
        logic                 is_empty;
        logic [COUNT_W-1:0]   count;
        logic [MAX_OUT_W-1:0] max_value;
    } t_status;

    // One row of the directed table: either a capacity write or an item
    typedef struct {
        bit                   is_cfg;
        t_mode                mode;
        logic [PRIO_IN_W-1:0] value;
        bit                   typed;
        t_status              want;
    } t_stim_row;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 i_cfg_valid   = 1'b0;
    logic                 o_cfg_ready;
    logic [CAP_W-1:0]     i_cfg_data    = '0;

    // Queue model state
    logic [PRIO_IN_W-1:0] mdl_store [Q_DEPTH];
    int                   mdl_len   = 0;
    logic [PRIO_IN_W-1:0] mdl_max   = '0;
    logic [CAP_W-1:0]     mdl_cap   = CAP_RESET;

    t_status              pending_status [$];
    t_stim_row            dir_tab [$];

    bit  src_idle_en = 1'b0;
    bit  snk_idle_en = 1'b0;
    int  stall_left  = 0;
    int  cycle_cnt   = 0;
    int  fail_cnt    = 0;
    int  n_items     = 0;
    int  n_checked   = 0;
    int  n_cfg       = 0;
    int  n_rejects   = 0;
    int  n_full_seen = 0;
    int  peak_count  = 0;

    max_priority_queue_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, pending_status.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // Mismatch report: one line each, all counted
    task automatic note_fail(string msg);
        fail_cnt++;
        $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
        if (got !== want)
            note_fail($sformatf("result %0d %s got %h want %h",
                                n_checked, name, got, want));
    endtask

    // Effective capacity saturates at the array depth
    function automatic int eff_capacity();
        return (int'(mdl_cap) > Q_DEPTH) ? Q_DEPTH : int'(mdl_cap);
    endfunction

    // Apply one operation to the model and return the status it leaves
    function automatic t_status queue_step(t_mode m, logic [PRIO_IN_W-1:0] p);
        t_status              r;
        int                   pos;
        logic [PRIO_IN_W-1:0] best;
        logic                 err;
        err = 1'b0;
        case (m)
            MODE_INSERT: begin
                if (mdl_len >= eff_capacity()) begin
                    err = 1'b1;
                end else begin
                    mdl_store[mdl_len] = p;
                    mdl_len++;
                    if (p > mdl_max) mdl_max = p;
                end
            end
            MODE_DELETE: begin
                if (mdl_len == 0) begin
                    err = 1'b1;
                end else begin
                    // first entry equal to the max, later entries move down
                    pos = 0;
                    while (pos < mdl_len && mdl_store[pos] != mdl_max) pos++;
                    if (pos < mdl_len) begin
                        for (int k = pos; k + 1 < mdl_len; k++)
                            mdl_store[k] = mdl_store[k + 1];
                        mdl_len--;
                    end
                    best = '0;
                    for (int k = 0; k < mdl_len; k++)
                        if (mdl_store[k] > best) best = mdl_store[k];
                    mdl_max = best;
                end
            end
            default: ;  // query and the spare code change nothing
        endcase
        r.max_value = mdl_max;
        r.count     = COUNT_W'(mdl_len);
        r.is_empty  = (mdl_len == 0);
        r.is_full   = (mdl_len >= eff_capacity());
        r.op_error  = err;
        return r;
    endfunction

    // Send one item; entered and left at a falling edge, tvalid left high
    task automatic push_item(t_mode m, logic [PRIO_IN_W-1:0] p, bit typed,
                             t_status want);
        t_status pred;
        if (src_idle_en && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= S_TDATA_W'($urandom);
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(S_TDATA_W - PRIO_IN_W - MODE_W){1'b0}}, p, m};
        do @(posedge i_clk); while (!s_axis_tready);
        pred = queue_step(m, p);
        pending_status.push_back(typed ? want : pred);
        n_items++;
        @(negedge i_clk);
    endtask

    // Drop tvalid and wait until every result is back
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= S_TDATA_W'($urandom);
        while (pending_status.size() != 0) @(negedge i_clk);
    endtask

    // Capacity write; only called with the queue block idle
    task automatic write_capacity(logic [CAP_W-1:0] cap);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= cap;
        do @(posedge i_clk); while (!o_cfg_ready);
        mdl_cap = cap;
        n_cfg++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= CAP_W'($urandom);
    endtask

    function automatic t_stim_row op_row(t_mode m, logic [PRIO_IN_W-1:0] p);
        t_stim_row r;
        r.is_cfg = 1'b0;
        r.mode   = m;
        r.value  = p;
        r.typed  = 1'b0;
        r.want   = '0;
        return r;
    endfunction

    function automatic t_stim_row chk_row(t_mode m, logic [PRIO_IN_W-1:0] p,
                                          logic [15:0] mx, logic [6:0] cnt,
                                          logic emp, logic full, logic err);
        t_stim_row r;
        r       = op_row(m, p);
        r.typed = 1'b1;
        r.want  = '{op_error: err, is_full: full, is_empty: emp, count: cnt,
                    max_value: mx};
        return r;
    endfunction

    function automatic t_stim_row cap_row(logic [CAP_W-1:0] c);
        t_stim_row r;
        r        = op_row(MODE_QUERY, 16'(c));
        r.is_cfg = 1'b1;
        return r;
    endfunction

    function automatic logic [PRIO_IN_W-1:0] rand_prio();
        case ($urandom_range(0, 7))
            0:       return PRIO_IN_W'($urandom_range(0, 7));   // duplicates
            1:       return $urandom_range(0, 1) ? '1 : '0;
            default: return PRIO_IN_W'($urandom);
        endcase
    endfunction

    // Output side stalls in bursts
    always @(negedge i_clk) begin
        if (stall_left > 0)
            stall_left--;
        else if (snk_idle_en && $urandom_range(0, 9) == 0)
            stall_left = $urandom_range(1, 12);
        m_axis_tready <= (stall_left == 0);
    end

    // Result checker
    always @(posedge i_clk) begin
        t_status got;
        t_status want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_status'(m_axis_tdata[25:0]);
            if (pending_status.size() == 0) begin
                note_fail($sformatf("unexpected result %h", m_axis_tdata));
            end else begin
                want = pending_status.pop_front();
                check_field("max_value", got.max_value, want.max_value);
                check_field("count",     16'(got.count),    16'(want.count));
                check_field("is_empty",  16'(got.is_empty), 16'(want.is_empty));
                check_field("is_full",   16'(got.is_full),  16'(want.is_full));
                check_field("op_error",  16'(got.op_error), 16'(want.op_error));
                n_checked++;
                n_rejects   += int'(want.op_error);
                n_full_seen += int'(want.is_full);
                if (int'(want.count) > peak_count) peak_count = int'(want.count);
            end
        end
    end

    // Stimulus
    initial begin
        int    ph_items;
        int    seg_len;
        int    ins_pct;
        int    r;
        bit    last_phase;
        t_mode m;

        // directed table: status after reset, extremes, rejects, capacity cases
        dir_tab.push_back(chk_row(MODE_QUERY,  16'hFFFF, 16'h0000, 0, 1, 0, 0));
        dir_tab.push_back(chk_row(MODE_DELETE, 16'h0000, 16'h0000, 0, 1, 0, 1));
        dir_tab.push_back(chk_row(MODE_RSVD,   16'h1234, 16'h0000, 0, 1, 0, 0));
        dir_tab.push_back(chk_row(MODE_INSERT, 16'h0000, 16'h0000, 1, 0, 0, 0));
        dir_tab.push_back(chk_row(MODE_INSERT, 16'hFFFF, 16'hFFFF, 2, 0, 0, 0));
        dir_tab.push_back(chk_row(MODE_INSERT, 16'h8000, 16'hFFFF, 3, 0, 0, 0));
        dir_tab.push_back(chk_row(MODE_INSERT, 16'hFFFF, 16'hFFFF, 4, 0, 0, 0));
        dir_tab.push_back(op_row (MODE_INSERT, 16'h5555));
        dir_tab.push_back(op_row (MODE_QUERY,  16'hAAAA));
        // duplicate max: only the first copy goes
        dir_tab.push_back(chk_row(MODE_DELETE, 16'h0000, 16'hFFFF, 4, 0, 0, 0));
        dir_tab.push_back(chk_row(MODE_DELETE, 16'hFFFF, 16'h8000, 3, 0, 0, 0));
        dir_tab.push_back(chk_row(MODE_DELETE, 16'h0000, 16'h5555, 2, 0, 0, 0));
        dir_tab.push_back(op_row (MODE_DELETE, 16'h0000));
        dir_tab.push_back(chk_row(MODE_DELETE, 16'h0000, 16'h0000, 0, 1, 0, 0));
        // capacity one
        dir_tab.push_back(cap_row(7'd1));
        dir_tab.push_back(chk_row(MODE_INSERT, 16'h0007, 16'h0007, 1, 0, 1, 0));
        dir_tab.push_back(chk_row(MODE_INSERT, 16'h0009, 16'h0007, 1, 0, 1, 1));
        dir_tab.push_back(chk_row(MODE_DELETE, 16'h0000, 16'h0000, 0, 1, 0, 0));
        // capacity zero: empty and full at once
        dir_tab.push_back(cap_row(7'd0));
        dir_tab.push_back(chk_row(MODE_INSERT, 16'h0003, 16'h0000, 0, 1, 1, 1));
        dir_tab.push_back(chk_row(MODE_QUERY,  16'h0000, 16'h0000, 0, 1, 1, 0));
        // capacity lowered under the fill level
        dir_tab.push_back(cap_row(7'd64));
        dir_tab.push_back(op_row (MODE_INSERT, 16'hAAAA));
        dir_tab.push_back(op_row (MODE_INSERT, 16'h0001));
        dir_tab.push_back(op_row (MODE_INSERT, 16'h0002));
        dir_tab.push_back(cap_row(7'd2));
        dir_tab.push_back(chk_row(MODE_INSERT, 16'h0004, 16'hAAAA, 3, 0, 1, 1));
        dir_tab.push_back(chk_row(MODE_DELETE, 16'h0000, 16'h0002, 2, 0, 1, 0));
        dir_tab.push_back(op_row (MODE_DELETE, 16'h0000));

        // hold reset low, then release it at a falling edge
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n     <= 1'b1;
        snk_idle_en <= 1'b1;
        src_idle_en  = 1'b1;
        @(negedge i_clk);

        foreach (dir_tab[i]) begin
            if (dir_tab[i].is_cfg) begin
                drain_results();
                write_capacity(dir_tab[i].value[CAP_W-1:0]);
            end else begin
                push_item(dir_tab[i].mode, dir_tab[i].value, dir_tab[i].typed,
                          dir_tab[i].want);
            end
        end

        // random phases, one capacity each; fill and drain runs inside
        for (int ph = 0; ph < 8; ph++) begin
            drain_results();
            case (ph)
                0: write_capacity(7'd127);
                1: write_capacity(7'd64);
                2: write_capacity(7'd1);
                3: write_capacity(7'd0);
                4: write_capacity(CAP_W'($urandom_range(2, 8)));
                5: write_capacity(CAP_W'($urandom_range(9, 63)));
                6: write_capacity(CAP_W'($urandom_range(65, 126)));
                default: write_capacity(7'd64);
            endcase
            last_phase = (ph == 7);
            ph_items   = (ph == 3) ? 40 : 260;
            while (ph_items > 0) begin
                seg_len = $urandom_range(4, 70);
                ins_pct = $urandom_range(0, 1) ? 85 : 20;
                src_idle_en  = !last_phase && ($urandom_range(0, 3) != 0);
                snk_idle_en <= !last_phase && ($urandom_range(0, 3) != 0);
                for (int k = 0; k < seg_len && ph_items > 0; k++) begin
                    r = $urandom_range(0, 99);
                    if (r < ins_pct)  m = MODE_INSERT;
                    else if (r < 95)  m = MODE_DELETE;
                    else              m = t_mode'($urandom_range(2, 3));
                    push_item(m, rand_prio(), 1'b0, '0);
                    ph_items--;
                end
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d items (%0d directed table rows), %0d capacity writes,",
                 n_items, dir_tab.size(), n_cfg);
        $display("checked %0d results: %0d rejected ops, %0d full reports, peak fill %0d",
                 n_checked, n_rejects, n_full_seen, peak_count);
        if (fail_cnt == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
